@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the UTF-8 decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ design/u8d_pkg.sv @@
// ---------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 code point decoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 10;
  localparam int unsigned PendW  = 2;

  // Configuration reset value
  localparam logic [CountW-1:0] MaxCharsRst = 10'd128;

  // Lead byte classification masks and patterns
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Data = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Data = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Data = 8'h07;
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContPat   = 8'h80;
  localparam logic [ByteW-1:0] ContData  = 8'h3F;
  localparam logic [ByteW-1:0] AsciiData = 8'h7F;

  // Substitute character '*' for malformed input
  localparam logic [CpW-1:0] SubstChar = 21'h00002A;

  // Continuation bytes still awaited
  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendOne   = 2'd1;
  localparam logic [PendW-1:0] PendTwo   = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

  // Decode result handed to the output register
  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic           bad;
  } dec_result_t;

endpackage

`default_nettype wire

@@ design/utf8_code_point_decoder_top.sv @@
// ---------------------------------------------------------------------------
// utf8_code_point_decoder_top
// UTF-8 byte stream to code point decoder, one byte per clock.
// ---------------------------------------------------------------------------
// Accepts one byte per clock and returns at most one 21-bit code point per
// byte. An accepted byte is held in the input register, decoded against the
// sequence state and loaded into the result register once that register is
// free or being drained; the result register drives out_valid. The sustained
// rate is one byte per cycle; it drops only while the result register holds
// a transaction that the consumer has not taken, which holds back the input
// register. Write max_chars only while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module utf8_code_point_decoder_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [u8d_pkg::ByteW-1:0]   in_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [u8d_pkg::CpW-1:0]          out_code_point,
  output logic                             out_bad_sequence,
  input  wire logic                        cfg_wr_en,
  input  wire logic [u8d_pkg::CountW-1:0]  cfg_wr_data
);

  logic [u8d_pkg::CountW-1:0] max_chars_r;
  logic                       stage_valid;
  logic [u8d_pkg::ByteW-1:0]  stage_byte;
  logic                       advance;
  u8d_pkg::dec_result_t       dec_res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= u8d_pkg::MaxCharsRst;
    end else if (cfg_wr_en) begin
      max_chars_r <= cfg_wr_data;
    end
  end

  // Byte leaves the stage when the result register can take its output
  assign advance = stage_valid && (!out_valid || out_ready);

  u8d_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  u8d_decode u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .stage_byte (stage_byte),
    .max_chars  (max_chars_r),
    .result     (dec_res)
  );

  u8d_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (advance && dec_res.emit),
    .result           (dec_res),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence)
  );

  // Assertions
  `ASSERT_IMPLIES(a_bad_is_subst, clk, rst_n, out_valid && out_bad_sequence, out_code_point == u8d_pkg::SubstChar)
  `ASSERT_IMPLIES(a_stall_holds_stage, clk, rst_n, out_valid && !out_ready, !advance)
  `ASSERT_NEXT(a_emit_shows, clk, rst_n, advance && dec_res.emit, out_valid)
  `ASSERT_IMPLIES(a_empty_stage_ready, clk, rst_n, !stage_valid, in_ready)

endmodule

`default_nettype wire

@@ design/u8d_in_stage.sv @@
// ---------------------------------------------------------------------------
// u8d_in_stage
// Input register: holds one accepted byte until the decoder consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module u8d_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [u8d_pkg::ByteW-1:0]   in_byte,
  input  wire logic                        advance,
  output logic                             stage_valid,
  output logic [u8d_pkg::ByteW-1:0]        stage_byte
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [u8d_pkg::ByteW-1:0] byte_r;
  logic                      take;

  // Stage is free when empty or being drained this cycle
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

endmodule

`default_nettype wire

@@ design/u8d_decode.sv @@
// ---------------------------------------------------------------------------
// u8d_decode
// Sequence state and combinational byte decode.
// ---------------------------------------------------------------------------
`default_nettype none

module u8d_decode (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        advance,
  input  wire logic [u8d_pkg::ByteW-1:0]   stage_byte,
  input  wire logic [u8d_pkg::CountW-1:0]  max_chars,
  output u8d_pkg::dec_result_t             result
);

  logic [u8d_pkg::PendW-1:0]  pend_r,    pend_nxt;
  logic [u8d_pkg::CpW-1:0]    partial_r, partial_nxt;
  logic [u8d_pkg::CountW-1:0] count_r,   count_nxt;
  logic [u8d_pkg::CpW-1:0]    shifted;
  logic [u8d_pkg::ByteW-1:0]  b;

  assign b       = stage_byte;
  // Six more payload bits from a continuation byte
  assign shifted = {partial_r[u8d_pkg::CpW-7:0], b[5:0]};

  // Next state and result for the byte in the stage
  always_comb begin
    pend_nxt          = pend_r;
    partial_nxt       = partial_r;
    count_nxt         = count_r;
    result.emit       = 1'b0;
    result.code_point = '0;
    result.bad        = 1'b0;

    if (b == '0) begin
      // terminator: clear everything, no output
      pend_nxt    = u8d_pkg::PendNone;
      partial_nxt = '0;
      count_nxt   = '0;
    end else if (count_r >= max_chars) begin
      // limit reached: drop byte
    end else if (pend_r == u8d_pkg::PendNone) begin
      if ((b & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Pat) begin
        partial_nxt = {13'd0, b & u8d_pkg::Lead2Data};
        pend_nxt    = u8d_pkg::PendOne;
      end else if ((b & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Pat) begin
        partial_nxt = {13'd0, b & u8d_pkg::Lead3Data};
        pend_nxt    = u8d_pkg::PendTwo;
      end else if ((b & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Pat) begin
        partial_nxt = {13'd0, b & u8d_pkg::Lead4Data};
        pend_nxt    = u8d_pkg::PendThree;
      end else if (b[7]) begin
        // stray continuation or invalid lead
        result.emit       = 1'b1;
        result.code_point = u8d_pkg::SubstChar;
        result.bad        = 1'b1;
      end else begin
        result.emit       = 1'b1;
        result.code_point = {13'd0, b & u8d_pkg::AsciiData};
      end
    end else if ((b & u8d_pkg::ContMask) == u8d_pkg::ContPat) begin
      pend_nxt = pend_r - u8d_pkg::PendOne;
      if (pend_r == u8d_pkg::PendOne) begin
        result.emit       = 1'b1;
        result.code_point = shifted;
        partial_nxt       = '0;
      end else begin
        partial_nxt = shifted;
      end
    end else begin
      // broken sequence: byte consumed, substitute emitted
      pend_nxt          = u8d_pkg::PendNone;
      partial_nxt       = '0;
      result.emit       = 1'b1;
      result.code_point = u8d_pkg::SubstChar;
      result.bad        = 1'b1;
    end

    if (result.emit) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // State update only when a byte leaves the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= u8d_pkg::PendNone;
      partial_r <= '0;
      count_r   <= '0;
    end else if (advance) begin
      pend_r    <= pend_nxt;
      partial_r <= partial_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/u8d_out_stage.sv @@
// ---------------------------------------------------------------------------
// u8d_out_stage
// Result register with valid/ready handshake toward the consumer.
// ---------------------------------------------------------------------------
`default_nettype none

module u8d_out_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire u8d_pkg::dec_result_t        result,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [u8d_pkg::CpW-1:0]          out_code_point,
  output logic                             out_bad_sequence
);

  logic                    valid_r;
  logic                    valid_nxt;
  logic [u8d_pkg::CpW-1:0] cp_r;
  logic                    bad_r;

  // Load wins; otherwise drop valid once the transaction completes
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r  <= result.code_point;
      bad_r <= result.bad;
    end
  end

  assign out_valid        = valid_r;
  assign out_code_point   = cp_r;
  assign out_bad_sequence = bad_r;

endmodule

`default_nettype wire
